>>> rtl/ordered_list_position_insert_delete_top_macros.svh
// ----------------------------------------------------------------------------
// ordered list assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_POSITION_INSERT_DELETE_TOP_MACROS_SVH
`define ORDERED_LIST_POSITION_INSERT_DELETE_TOP_MACROS_SVH

// same-cycle implication
`define OLPID_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olpid: same-cycle check failed");

// next-cycle implication
`define OLPID_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olpid: next-cycle check failed");

`endif

>>> rtl/olpid_pkg.sv
// ----------------------------------------------------------------------------
// olpid_pkg
// sizes, action and status codes, controller/datapath interface types
// ----------------------------------------------------------------------------
package olpid_pkg;

  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = 8;

  localparam int ACT_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int ST_W  = 2;
  localparam int LEN_W = 6;

  typedef logic [ACT_W-1:0] action_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam action_t ACT_INS_FRONT = 3'd0;
  localparam action_t ACT_INS_POS   = 3'd1;
  localparam action_t ACT_INS_END   = 3'd2;
  localparam action_t ACT_DEL_FRONT = 3'd3;
  localparam action_t ACT_DEL_POS   = 3'd4;
  localparam action_t ACT_DEL_END   = 3'd5;
  localparam action_t ACT_READ      = 3'd6;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_BADPOS = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

  typedef struct packed {
    logic              load_val;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_sel_val;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              emit;
    logic              emit_item;
    logic              emit_last;
    status_t           emit_status;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

>>> rtl/ordered_list_position_insert_delete_top.sv
// ----------------------------------------------------------------------------
// ordered_list_position_insert_delete_top
// ordered list of signed words with positional insert, delete and read-out
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ---------------------------
//  input     in_action, in_value, in_position        start high, busy low
//  result    out_status, out_item_value, out_last,   out_strobe, one cycle,
//            out_length                              no back-pressure
//
//  sequence: busy stays high after an accepted beat through decode and, by action,
//    errors, delete end, read-out of an empty list, unused action: report
//    insert: shift pass and drain if any element moves (count - slot), place, report
//    delete front or at position: shift pass and drain if any element moves, report
//    read-out: one read per element, then drain; one result beat per cycle
//  the entry table has one read and one write port: each element moved costs
//  one read and one write through it, the write in the cycle after the read
//  reset is synchronous on rst_n low and empties the list; table contents are
//  left as they were and only slots below the count are ever read
//  results cannot be stalled; busy stays high until the last beat is loaded,
//  that beat shows on the result ports in the same cycle that busy drops
//
module ordered_list_position_insert_delete_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // command side
  input  logic                               start,
  output logic                               busy,
  input  logic [olpid_pkg::ACT_W-1:0]        in_action,
  input  logic signed [olpid_pkg::VAL_W-1:0] in_value,
  input  logic [olpid_pkg::POS_W-1:0]        in_position,
  // result side
  output logic                               out_strobe,
  output logic [olpid_pkg::ST_W-1:0]         out_status,
  output logic signed [olpid_pkg::VAL_W-1:0] out_item_value,
  output logic                               out_last,
  output logic [olpid_pkg::LEN_W-1:0]        out_length
);
  import olpid_pkg::*;

  // controller drives the table through cmd, watches the count through stat
  cmd_t  cmd;
  stat_t stat;

  // sequencer: decode, shift passes, read-out walk, status report
  olpid_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_position (in_position),
    .stat        (stat),
    .cmd         (cmd)
  );

  // table, count and registered result beat
  olpid_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_last       (out_last),
    .out_length     (out_length)
  );

endmodule

>>> rtl/olpid_ctrl.sv
// ----------------------------------------------------------------------------
// olpid_ctrl
// sequencer: decodes an action, walks shift and read-out passes
// ----------------------------------------------------------------------------
`include "ordered_list_position_insert_delete_top_macros.svh"

module olpid_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [olpid_pkg::ACT_W-1:0]    in_action,
  input  logic [olpid_pkg::POS_W-1:0]    in_position,
  input  olpid_pkg::stat_t               stat,
  output olpid_pkg::cmd_t                cmd
);
  import olpid_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_RDRAIN = 3'd6;
  localparam logic [2:0] S_REPORT = 3'd7;

  logic [2:0]        state_r, state_nxt;
  action_t           act_r, act_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              ins_r, ins_nxt;
  status_t           status_r, status_nxt;
  logic              wv_r, wv_nxt;
  logic [ADDR_W-1:0] waddr_r, waddr_nxt;
  logic              ev_r, ev_nxt;
  logic              elast_r, elast_nxt;

  logic              accept;
  logic [CMP_W-1:0]  cnt_x, cnt_m1, pos_x, ptr_x;
  logic [CMP_W-1:0]  ins_t, del_t, idx_x;
  logic              full, empty, at_tail;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign cnt_x  = CMP_W'(stat.count);
  assign cnt_m1 = cnt_x - CMP_W'(1);
  assign pos_x  = CMP_W'(pos_r);
  assign ptr_x  = CMP_W'(ptr_r);
  assign full   = (cnt_x == CMP_W'(DEPTH));
  assign empty  = (cnt_x == '0);
  assign at_tail = (ptr_x == cnt_m1);

  // slot for insert at position (position - 1, at least 1), element to drop for delete at position
  assign ins_t = (pos_x > CMP_W'(2)) ? pos_x - CMP_W'(1) : CMP_W'(1);
  assign del_t = (act_r == ACT_DEL_FRONT) ? CMP_W'(1)
               : ((pos_x > CMP_W'(1)) ? pos_x : CMP_W'(1));

  always_comb begin
    unique case (act_r)
      ACT_INS_FRONT: idx_x = '0;
      ACT_INS_POS:   idx_x = ins_t;
      default:       idx_x = cnt_x;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    pos_nxt    = pos_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    ins_nxt    = ins_r;
    status_nxt = status_r;
    wv_nxt     = 1'b0;
    waddr_nxt  = waddr_r;
    ev_nxt     = 1'b0;
    elast_nxt  = elast_r;

    cmd             = '0;
    cmd.load_val    = accept;
    cmd.wr_en       = wv_r;
    cmd.wr_addr     = waddr_r;
    cmd.emit        = ev_r;
    cmd.emit_item   = ev_r;
    cmd.emit_last   = elast_r;
    cmd.emit_status = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt   = in_action;
          pos_nxt   = in_position;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        status_nxt = ST_OK;
        state_nxt  = S_REPORT;
        unique case (act_r) inside
          ACT_INS_FRONT, ACT_INS_POS, ACT_INS_END: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else if (act_r == ACT_INS_POS && ins_t > cnt_x) begin
              status_nxt = ST_BADPOS;
            end else begin
              idx_nxt = idx_x[ADDR_W-1:0];
              ins_nxt = 1'b1;
              ptr_nxt = cnt_m1[ADDR_W-1:0];
              state_nxt = (idx_x == cnt_x) ? S_PLACE : S_SHIFT;
            end
          end
          ACT_DEL_FRONT, ACT_DEL_POS: begin
            if (empty && act_r == ACT_DEL_FRONT) begin
              status_nxt = ST_EMPTY;
            end else if (del_t > cnt_x) begin
              status_nxt = ST_BADPOS;
            end else if (del_t == cnt_x) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              ins_nxt   = 1'b0;
              ptr_nxt   = del_t[ADDR_W-1:0];
              state_nxt = S_SHIFT;
            end
          end
          ACT_DEL_END: begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              cmd.cnt_dec = 1'b1;
            end
          end
          ACT_READ: begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              ptr_nxt   = '0;
              state_nxt = S_READ;
            end
          end
          default: status_nxt = ST_OK;
        endcase
      end
      S_SHIFT: begin
        // read one slot, write it one place over in the next cycle
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = ptr_r;
        wv_nxt      = 1'b1;
        waddr_nxt   = ins_r ? ptr_r + ADDR_W'(1) : ptr_r - ADDR_W'(1);
        if (ins_r ? (ptr_r == idx_r) : at_tail) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ins_r ? ptr_r - ADDR_W'(1) : ptr_r + ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        if (ins_r) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_REPORT;
        end
      end
      S_PLACE: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_addr    = idx_r;
        cmd.wr_sel_val = 1'b1;
        cmd.cnt_inc    = 1'b1;
        state_nxt      = S_REPORT;
      end
      S_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = ptr_r;
        ev_nxt      = 1'b1;
        elast_nxt   = at_tail;
        if (at_tail) begin
          state_nxt = S_RDRAIN;
        end else begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      S_RDRAIN: begin
        state_nxt = S_IDLE;
      end
      S_REPORT: begin
        cmd.emit        = 1'b1;
        cmd.emit_item   = 1'b0;
        cmd.emit_last   = 1'b1;
        cmd.emit_status = status_r;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wv_r    <= 1'b0;
      ev_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wv_r    <= wv_nxt;
      ev_r    <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    pos_r    <= pos_nxt;
    ptr_r    <= ptr_nxt;
    idx_r    <= idx_nxt;
    ins_r    <= ins_nxt;
    status_r <= status_nxt;
    waddr_r  <= waddr_nxt;
    elast_r  <= elast_nxt;
  end

  `OLPID_ASSERT_IMP(a_idle_no_pending, state_r == S_IDLE, !wv_r && !ev_r)
  `OLPID_ASSERT_IMP(a_place_port_free, state_r == S_PLACE, !wv_r)
  `OLPID_ASSERT_NXT(a_accept_decodes, accept, state_r == S_DECODE)
  `OLPID_ASSERT_NXT(a_report_ends, state_r == S_REPORT, state_r == S_IDLE)
  `OLPID_ASSERT_IMP(a_count_bound, 1'b1, CMP_W'(stat.count) <= CMP_W'(DEPTH))

endmodule

>>> rtl/olpid_dp.sv
// ----------------------------------------------------------------------------
// olpid_dp
// entry table, element count, insert value and result register
// ----------------------------------------------------------------------------
module olpid_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  olpid_pkg::cmd_t                    cmd,
  output olpid_pkg::stat_t                   stat,
  input  logic signed [olpid_pkg::VAL_W-1:0] in_value,
  output logic                               out_strobe,
  output logic [olpid_pkg::ST_W-1:0]         out_status,
  output logic signed [olpid_pkg::VAL_W-1:0] out_item_value,
  output logic                               out_last,
  output logic [olpid_pkg::LEN_W-1:0]        out_length
);
  import olpid_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] wr_data;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             strobe_r;
  status_t          status_r;
  logic [VAL_W-1:0] item_r;
  logic             last_r;
  logic [LEN_W-1:0] length_r;

  assign wr_data = cmd.wr_sel_val ? value_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_val) begin
      value_r <= in_value;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r <= cmd.emit_status;
      item_r   <= cmd.emit_item ? rd_data_r : '0;
      last_r   <= cmd.emit_last;
      length_r <= LEN_W'(count_r);
    end
  end

  assign stat.count     = count_r;
  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_item_value = item_r;
  assign out_last       = last_r;
  assign out_length     = length_r;

endmodule
